FILE: hw/rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the circulation pump controller.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TEMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_ON  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERG_HEAT = 3'd5;

  // Reset values of the configuration registers
  localparam logic signed [15:0] RST_OFF_TEMP   = 16'sd0;
  localparam logic signed [15:0] RST_ON_TEMP    = 16'sd0;
  localparam logic [31:0]        RST_MAX_OFF    = 32'd7200;
  localparam logic [15:0]        RST_LAG        = 16'd120;
  localparam logic [15:0]        RST_FORCED_ON  = 16'd600;
  localparam logic               RST_EMERG_HEAT = 1'b0;

  typedef struct packed {
    logic signed [15:0] off_temperature;
    logic signed [15:0] on_temperature;
    logic [31:0]        max_off_seconds;
    logic [15:0]        lag_seconds;
    logic [15:0]        forced_on_seconds;
    logic               emergency_heating_enabled;
  } cfg_t;

  typedef struct packed {
    logic               second_tick;
    logic signed [15:0] buffer_temp;
    logic               thermostat_contact;
    logic               heating_active;
    logic               sterilisation_active;
    logic               hot_water_in_tank_state;
    logic               mode_allows_run;
  } step_t;

  typedef struct packed {
    logic       pump_on;
    logic [2:0] phase;
    logic       too_cold;
  } result_t;

endpackage

FILE: hw/rtl/cpc_if.sv
// ----------------------------------------------------------------------------
// cpc_if
// Valid/ready channels of the pump controller: step items in, results out.
// ----------------------------------------------------------------------------
interface cpc_in_if;
  logic               valid;
  logic               ready;
  logic               second_tick;
  logic signed [15:0] buffer_temp;
  logic               thermostat_contact;
  logic               heating_active;
  logic               sterilisation_active;
  logic               hot_water_in_tank_state;
  logic               mode_allows_run;

  modport source (
    output valid, second_tick, buffer_temp, thermostat_contact, heating_active,
           sterilisation_active, hot_water_in_tank_state, mode_allows_run,
    input  ready
  );
  modport sink (
    input  valid, second_tick, buffer_temp, thermostat_contact, heating_active,
           sterilisation_active, hot_water_in_tank_state, mode_allows_run,
    output ready
  );
endinterface

interface cpc_out_if;
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic [2:0] phase;
  logic       too_cold;

  modport source (output valid, pump_on, phase, too_cold, input ready);
  modport sink   (input valid, pump_on, phase, too_cold, output ready);
endinterface

FILE: hw/rtl/cpc_cfg.sv
// ----------------------------------------------------------------------------
// cpc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cpc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output cpc_pkg::cfg_t                      cfg
);
  import cpc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_temperature           <= RST_OFF_TEMP;
      cfg_r.on_temperature            <= RST_ON_TEMP;
      cfg_r.max_off_seconds           <= RST_MAX_OFF;
      cfg_r.lag_seconds               <= RST_LAG;
      cfg_r.forced_on_seconds         <= RST_FORCED_ON;
      cfg_r.emergency_heating_enabled <= RST_EMERG_HEAT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFF_TEMP:   cfg_r.off_temperature           <= $signed(cfg_wdata[15:0]);
        CFG_ON_TEMP:    cfg_r.on_temperature            <= $signed(cfg_wdata[15:0]);
        CFG_MAX_OFF:    cfg_r.max_off_seconds           <= cfg_wdata[31:0];
        CFG_LAG:        cfg_r.lag_seconds               <= cfg_wdata[15:0];
        CFG_FORCED_ON:  cfg_r.forced_on_seconds         <= cfg_wdata[15:0];
        CFG_EMERG_HEAT: cfg_r.emergency_heating_enabled <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/cpc_ctrl.sv
// ----------------------------------------------------------------------------
// cpc_ctrl
// Controller state (phase, seconds counter, cold flag, drive) and the
// single-pass step logic that advances it.
// ----------------------------------------------------------------------------
module cpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  cpc_pkg::step_t    step,
  input  cpc_pkg::cfg_t     cfg,
  output cpc_pkg::result_t  res
);
  import cpc_pkg::*;

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_OFF    = 3'd1,
    PH_ON     = 3'd2,
    PH_LAG    = 3'd3,
    PH_FORCED = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt, cnt_tick;
  logic        cold_r, cold_nxt, cold_upd;
  logic        drive_r, drive_nxt;
  logic        cond;
  logic        off_due, lag_due, forced_due;

  // saturating seconds counter
  assign cnt_tick = (step.second_tick && (cnt_r != '1)) ? cnt_r + 32'd1 : cnt_r;

  // low temperature flag with hysteresis
  always_comb begin
    if (cfg.off_temperature >= cfg.on_temperature)   cold_upd = 1'b0;
    else if (step.buffer_temp <= cfg.off_temperature) cold_upd = 1'b1;
    else if (step.buffer_temp >= cfg.on_temperature)  cold_upd = 1'b0;
    else                                              cold_upd = cold_r;
  end

  assign cond = !(cold_upd && step.heating_active) && !step.sterilisation_active &&
                ((cfg.emergency_heating_enabled && step.hot_water_in_tank_state) ||
                 step.mode_allows_run);

  assign off_due    = cnt_tick >= cfg.max_off_seconds;
  assign lag_due    = cnt_tick >= {16'd0, cfg.lag_seconds};
  assign forced_due = cnt_tick >= {16'd0, cfg.forced_on_seconds};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_tick;
    cold_nxt  = cold_upd;
    drive_nxt = drive_r;
    unique case (phase_r)
      PH_INIT: begin
        phase_nxt = PH_OFF;
        cnt_nxt   = '0;
        drive_nxt = 1'b0;
        cold_nxt  = 1'b0;
      end
      PH_OFF: begin
        if (cond && step.thermostat_contact) begin
          phase_nxt = PH_ON;
          cnt_nxt   = '0;
          drive_nxt = 1'b1;
        end else if (off_due) begin
          phase_nxt = PH_FORCED;
          cnt_nxt   = '0;
          drive_nxt = 1'b1;
        end
      end
      PH_ON: begin
        if (!cond) begin
          phase_nxt = PH_OFF;
          cnt_nxt   = '0;
          drive_nxt = 1'b0;
        end else if (!step.thermostat_contact) begin
          phase_nxt = PH_LAG;
          cnt_nxt   = '0;
        end
      end
      PH_LAG: begin
        if (!cond || (!step.thermostat_contact && lag_due)) begin
          phase_nxt = PH_OFF;
          cnt_nxt   = '0;
          drive_nxt = 1'b0;
        end else if (step.thermostat_contact) begin
          phase_nxt = PH_ON;
          cnt_nxt   = '0;
        end
      end
      PH_FORCED: begin
        if (forced_due) begin
          phase_nxt = PH_OFF;
          cnt_nxt   = '0;
          drive_nxt = 1'b0;
        end
      end
      default: begin
        // corrupted phase: start over
        phase_nxt = PH_INIT;
        cnt_nxt   = '0;
        drive_nxt = 1'b0;
        cold_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
      cnt_r   <= '0;
      cold_r  <= 1'b0;
      drive_r <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cold_r  <= cold_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign res.pump_on  = drive_nxt;
  assign res.phase    = phase_nxt;
  assign res.too_cold = cold_nxt;

  // drive follows the phase: running exactly in on, lag and forced-on
  a_drive_phase: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r == (phase_r == PH_ON || phase_r == PH_LAG || phase_r == PH_FORCED))
    else $error("pump drive inconsistent with phase");

  // init always leaves to off with a cleared counter and flag
  a_init_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && phase_r == PH_INIT) |=> (phase_r == PH_OFF && cnt_r == '0 && !cold_r))
    else $error("init step did not enter off cleanly");

  // counter only moves on a step
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cnt_r))
    else $error("seconds counter changed without a step");

endmodule

FILE: hw/rtl/circulation_pump_controller_top.sv
// ----------------------------------------------------------------------------
// circulation_pump_controller_top
// Circulation pump controller: one result per step item, phase machine with
// lag and forced-on timing, hysteresis on buffer temperature.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  in_if   | in  | valid/ready         | second_tick, buffer_temp, contact,
//          |     |                     | mode flags (one task step)
//  out_if  | out | valid/ready         | pump_on, phase, too_cold
//  cfg_*   | in  | cfg_we, no stall    | cfg_index, cfg_wdata (6 registers)
//
//  Each item passes the input register, then the result register, where its
//    result is held until it transfers on out_if. Throughput: one item per cycle
//    while out_if does not stall.
//  The step logic sits between the input register and the result register;
//    controller state updates in the cycle the item moves into the result register.
//  Reset (rst_n low, synchronous) empties both stages, sets the phase to init
//    and loads the configuration reset values. No clearing pass.
//  A stall on out_if holds the result; the input register fills and in_if.ready
//    drops only when both stages are occupied.
// ----------------------------------------------------------------------------
module circulation_pump_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  cpc_in_if.sink                         in_if,
  cpc_out_if.source                      out_if
);
  import cpc_pkg::*;

  cfg_t    cfg;
  step_t   s1_data_r;
  logic    s1_valid_r;
  result_t res, out_data_r;
  logic    out_valid_r;
  logic    adv;        // item moves from input register to result register
  logic    in_xfer;

  // step item advances when the result register is free or being drained
  assign adv     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;
  assign in_xfer = in_if.valid && in_if.ready;

  cpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .step  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register: control under reset, payload only loads on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r.second_tick             <= in_if.second_tick;
      s1_data_r.buffer_temp             <= in_if.buffer_temp;
      s1_data_r.thermostat_contact      <= in_if.thermostat_contact;
      s1_data_r.heating_active          <= in_if.heating_active;
      s1_data_r.sterilisation_active    <= in_if.sterilisation_active;
      s1_data_r.hot_water_in_tank_state <= in_if.hot_water_in_tank_state;
      s1_data_r.mode_allows_run         <= in_if.mode_allows_run;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.pump_on  = out_data_r.pump_on;
  assign out_if.phase    = out_data_r.phase;
  assign out_if.too_cold = out_data_r.too_cold;

  // every advanced item shows up as a result next cycle
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  // a waiting input item is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("stalled input item lost");

  // a held result is not overwritten while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result overwritten");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("stages not empty after reset");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circulation_pump_controller_top. A short table of
// directed steps walks every phase, then random steps run under several register
// settings. Each result transfer is checked in order against the row's own result
// where a row gives one, else a pump controller copy that steps once per accepted item.
// ----------------------------------------------------------------------------
module testbench;
  import cpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 300000;
  localparam int unsigned RANDOM_SETTINGS   = 6;
  localparam int unsigned STEPS_PER_SETTING = 150;
  localparam int unsigned HOLD_CYCLES       = 60;
  localparam int unsigned REPORT_LIMIT      = 10;
  localparam int unsigned DIRECTED_ROWS     = 24;

  typedef enum logic [2:0] {
    PHASE_INIT   = 3'd0,
    PHASE_OFF    = 3'd1,
    PHASE_RUN    = 3'd2,
    PHASE_LAG    = 3'd3,
    PHASE_FORCED = 3'd4
  } phase_e;

  // Per-item note: when typed_in is set, the hand-written value replaces
  // the model's prediction for that item.
  typedef struct packed {
    logic    typed_in;
    result_t want;
  } preset_t;

  typedef struct packed {
    logic [1:0] grp;
    step_t      s;
    logic       typed_in;
    result_t    want;
  } drow_t;

  // Register groups used by the directed table. Group 0 is the reset state
  // and is never written, so the first rows also check the reset values.
  localparam cfg_t DIRECTED_CFG [3] = '{
    '{RST_OFF_TEMP, RST_ON_TEMP, RST_MAX_OFF, RST_LAG, RST_FORCED_ON, RST_EMERG_HEAT},
    '{-16'sd100, 16'sd100, 32'd3, 16'd2, 16'd2, 1'b1},
    '{16'sh7FFF, 16'sh8000, 32'd0, 16'd0, 16'd0, 1'b0}
  };

  // Directed steps.
  //   step fields: tick, temp, contact, heating, steril, hw_tank, mode_ok
  //   result:      pump_on, phase, too_cold
  localparam drow_t DIRECTED [DIRECTED_ROWS] = '{
    // reset thresholds are equal (0/0), so the cold flag stays clear
    '{2'd0, '{0, 16'sd0,      0, 0, 0, 0, 0}, 1, '{0, PHASE_OFF,    0}}, // leave init
    '{2'd0, '{1, 16'sh8000,   1, 1, 0, 0, 1}, 1, '{1, PHASE_RUN,    0}},
    '{2'd0, '{0, 16'sh7FFF,   0, 1, 0, 0, 1}, 1, '{1, PHASE_LAG,    0}},
    '{2'd0, '{1, 16'sd0,      0, 0, 0, 0, 1}, 1, '{1, PHASE_LAG,    0}},
    '{2'd0, '{0, 16'sd0,      1, 0, 0, 0, 1}, 1, '{1, PHASE_RUN,    0}},
    '{2'd0, '{0, 16'sd0,      1, 0, 1, 0, 1}, 1, '{0, PHASE_OFF,    0}}, // sterilisation
    '{2'd0, '{0, 16'sh7FFF,   1, 0, 0, 1, 0}, 1, '{0, PHASE_OFF,    0}}, // no emergency
    // thresholds -100/100, short timers, emergency heating on
    '{2'd1, '{0, -16'sd100,   1, 1, 0, 0, 1}, 1, '{0, PHASE_OFF,    1}}, // cold blocks
    '{2'd1, '{0, 16'sd0,      1, 0, 0, 1, 0}, 1, '{1, PHASE_RUN,    1}}, // flag held
    '{2'd1, '{1, 16'sd100,    0, 0, 0, 0, 1}, 1, '{1, PHASE_LAG,    0}},
    '{2'd1, '{1, 16'sd0,      0, 0, 0, 0, 1}, 1, '{1, PHASE_LAG,    0}},
    '{2'd1, '{1, 16'sd0,      0, 0, 0, 0, 1}, 1, '{0, PHASE_OFF,    0}}, // lag expires
    '{2'd1, '{1, 16'sd0,      0, 0, 0, 0, 1}, 1, '{0, PHASE_OFF,    0}},
    '{2'd1, '{1, 16'sd0,      0, 0, 0, 0, 1}, 1, '{0, PHASE_OFF,    0}},
    '{2'd1, '{1, 16'sd0,      0, 0, 0, 0, 1}, 1, '{1, PHASE_FORCED, 0}}, // off too long
    '{2'd1, '{1, 16'sd0,      0, 0, 1, 0, 0}, 1, '{1, PHASE_FORCED, 0}},
    '{2'd1, '{1, 16'sd0,      0, 0, 0, 0, 1}, 1, '{0, PHASE_OFF,    0}},
    '{2'd1, '{0, -16'sd1,     0, 1, 0, 1, 1}, 0, '{0, PHASE_INIT,   0}},
    '{2'd1, '{0, 16'sh8000,   1, 1, 0, 1, 0}, 0, '{0, PHASE_INIT,   0}},
    // inverted thresholds, all timers zero
    '{2'd2, '{0, 16'sh8000,   0, 1, 0, 0, 1}, 1, '{1, PHASE_FORCED, 0}},
    '{2'd2, '{0, 16'sd0,      0, 0, 0, 0, 0}, 1, '{0, PHASE_OFF,    0}},
    '{2'd2, '{0, 16'sh7FFF,   1, 1, 0, 0, 1}, 1, '{1, PHASE_RUN,    0}},
    '{2'd2, '{0, 16'sd0,      0, 0, 0, 0, 1}, 1, '{1, PHASE_LAG,    0}},
    '{2'd2, '{0, 16'sd0,      0, 0, 0, 0, 1}, 1, '{0, PHASE_OFF,    0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cpc_in_if  step_ch ();
  cpc_out_if result_ch ();

  circulation_pump_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (step_ch),
    .out_if    (result_ch)
  );

  // Controller copy: registers and state as the block should hold them.
  cfg_t        live_cfg    = '{RST_OFF_TEMP, RST_ON_TEMP, RST_MAX_OFF, RST_LAG,
                               RST_FORCED_ON, RST_EMERG_HEAT};
  phase_e      model_phase = PHASE_INIT;
  logic [31:0] model_secs  = '0;
  logic        model_cold  = 1'b0;
  logic        model_drive = 1'b0;

  result_t     pending_results [$];  // expected results, oldest first
  preset_t     presets [$];          // one per offered item, popped on transfer

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned steps_sent      = 0;
  int unsigned settings_used   = 0;
  int unsigned cycles          = 0;
  int unsigned phase_hits [8]  = '{default: 0};
  bit          hold_req        = 1'b0;  // asks the receiver for one long hold-off
  bit          hold_done       = 1'b0;  // receiver has served the hold-off
  bit          quiet           = 1'b0;  // no idling on either side
  logic        contact_level   = 1'b0;  // slow-moving thermostat contact

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that hangs on a lost result ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results still pending",
               cycles, pending_results.size());
      $display("** circulation_pump_controller_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller copy. Order within a step: tick the seconds counter, update the
  // cold flag with hysteresis, then move the phase machine. Any phase change
  // restarts the counter.
  // ---------------------------------------------------------------------------
  function automatic void enter_phase(phase_e nxt, logic drive);
    model_secs  = '0;
    model_drive = drive;
    model_phase = nxt;
  endfunction

  function automatic result_t advance_pump(step_t s);
    logic    run_ok;
    result_t r;
    if (s.second_tick && model_secs != 32'hFFFF_FFFF) model_secs = model_secs + 32'd1;

    // Inverted (or equal) thresholds disable the flag; between them it holds.
    if ($signed(live_cfg.off_temperature) >= $signed(live_cfg.on_temperature))
      model_cold = 1'b0;
    else if ($signed(s.buffer_temp) <= $signed(live_cfg.off_temperature))
      model_cold = 1'b1;
    else if ($signed(s.buffer_temp) >= $signed(live_cfg.on_temperature))
      model_cold = 1'b0;

    run_ok = !(model_cold && s.heating_active) && !s.sterilisation_active &&
             ((live_cfg.emergency_heating_enabled && s.hot_water_in_tank_state) ||
              s.mode_allows_run);

    case (model_phase)
      PHASE_INIT: begin
        enter_phase(PHASE_OFF, 1'b0);
        model_cold = 1'b0;  // init step always reports the flag clear
      end
      PHASE_OFF: begin
        if (run_ok && s.thermostat_contact) enter_phase(PHASE_RUN, 1'b1);
        else if (model_secs >= live_cfg.max_off_seconds) enter_phase(PHASE_FORCED, 1'b1);
      end
      PHASE_RUN: begin
        if (!run_ok) enter_phase(PHASE_OFF, 1'b0);
        else if (!s.thermostat_contact) enter_phase(PHASE_LAG, model_drive);
      end
      PHASE_LAG: begin
        if (!run_ok) enter_phase(PHASE_OFF, 1'b0);
        else if (s.thermostat_contact) enter_phase(PHASE_RUN, model_drive);
        else if (model_secs >= {16'd0, live_cfg.lag_seconds}) enter_phase(PHASE_OFF, 1'b0);
      end
      PHASE_FORCED: begin
        // forced run ignores the run conditions
        if (model_secs >= {16'd0, live_cfg.forced_on_seconds}) enter_phase(PHASE_OFF, 1'b0);
      end
      default: begin
        enter_phase(PHASE_INIT, 1'b0);
        model_cold = 1'b0;
      end
    endcase

    r.pump_on  = model_drive;
    r.phase    = model_phase;
    r.too_cold = model_cold;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Both channels are watched from one process: result transfers are checked
  // first, then an input transfer at the same edge steps the controller copy.
  // All bench drives are nonblocking, so values read here are pre-edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    preset_t p;
    step_t   s;
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready) begin
        got.pump_on  = result_ch.pump_on;
        got.phase    = result_ch.phase;
        got.too_cold = result_ch.too_cold;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with nothing pending: pump_on %0d phase %0d too_cold %0d",
                                 got.pump_on, got.phase, got.too_cold));
        end else begin
          want = pending_results.pop_front();
          if (got.pump_on !== want.pump_on)
            note_failure($sformatf("result %0d pump_on: expected %0d, got %0d",
                                   results_checked, want.pump_on, got.pump_on));
          if (got.phase !== want.phase)
            note_failure($sformatf("result %0d phase: expected %0d, got %0d",
                                   results_checked, want.phase, got.phase));
          if (got.too_cold !== want.too_cold)
            note_failure($sformatf("result %0d too_cold: expected %0d, got %0d",
                                   results_checked, want.too_cold, got.too_cold));
          results_checked++;
        end
      end

      if (step_ch.valid && step_ch.ready) begin
        s.second_tick             = step_ch.second_tick;
        s.buffer_temp             = step_ch.buffer_temp;
        s.thermostat_contact      = step_ch.thermostat_contact;
        s.heating_active          = step_ch.heating_active;
        s.sterilisation_active    = step_ch.sterilisation_active;
        s.hot_water_in_tank_state = step_ch.hot_water_in_tank_state;
        s.mode_allows_run         = step_ch.mode_allows_run;
        want = advance_pump(s);
        phase_hits[want.phase]++;
        // the copy always steps; a hand-written row only overrides what is expected
        if (presets.size() != 0) begin
          p = presets.pop_front();
          if (p.typed_in) want = p.want;
        end
        pending_results.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls between ready runs, one long hold-off on
  // request, and steady ready once the run goes quiet.
  // ---------------------------------------------------------------------------
  initial begin
    result_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one step and return at the edge of its transfer. valid stays high,
  // so a following offer keeps the channel busy without a bubble.
  task automatic offer_step(step_t s, logic typed_in, result_t want);
    presets.push_back('{typed_in, want});
    step_ch.valid                   <= 1'b1;
    step_ch.second_tick             <= s.second_tick;
    step_ch.buffer_temp             <= s.buffer_temp;
    step_ch.thermostat_contact      <= s.thermostat_contact;
    step_ch.heating_active          <= s.heating_active;
    step_ch.sterilisation_active    <= s.sterilisation_active;
    step_ch.hot_water_in_tank_state <= s.hot_water_in_tank_state;
    step_ch.mode_allows_run         <= s.mode_allows_run;
    @(posedge clk);
    while (!step_ch.ready) @(posedge clk);
    steps_sent++;
  endtask

  task automatic idle_steps(int unsigned n);
    step_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait for every expected result. Each step yields
  // exactly one result, so an empty queue means the pipe is empty too.
  task automatic wait_drained();
    step_ch.valid <= 1'b0;
    @(posedge clk);
    while (presets.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all six registers back to back, then mirror them in the copy.
  task automatic load_settings(cfg_t c);
    put_reg(CFG_OFF_TEMP,   {{16{c.off_temperature[15]}}, c.off_temperature});
    put_reg(CFG_ON_TEMP,    {{16{c.on_temperature[15]}}, c.on_temperature});
    put_reg(CFG_MAX_OFF,    c.max_off_seconds);
    put_reg(CFG_LAG,        {16'd0, c.lag_seconds});
    put_reg(CFG_FORCED_ON,  {16'd0, c.forced_on_seconds});
    put_reg(CFG_EMERG_HEAT, {31'd0, c.emergency_heating_enabled});
    cfg_we   <= 1'b0;
    live_cfg  = c;
    settings_used++;
  endtask

  // Random step. The contact moves slowly so that on/lag/off sequences play
  // out; temperatures cluster around the thresholds so the hysteresis flips,
  // with full-range and extreme values mixed in.
  function automatic step_t random_step();
    step_t s;
    int    t;
    if ($urandom_range(0, 5) == 0) contact_level = ~contact_level;
    case ($urandom_range(0, 5))
      0: t = int'($signed(live_cfg.off_temperature)) + int'($urandom_range(0, 6)) - 3;
      1: t = int'($signed(live_cfg.on_temperature)) + int'($urandom_range(0, 6)) - 3;
      2: t = (int'($signed(live_cfg.off_temperature)) +
              int'($signed(live_cfg.on_temperature))) / 2;
      3: t = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: t = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (t > 32767) t = 32767;
    else if (t < -32768) t = -32768;
    s.second_tick             = ($urandom_range(0, 9) < 7);
    s.buffer_temp             = t[15:0];
    // occasional chatter on the contact
    s.thermostat_contact      = ($urandom_range(0, 15) == 0) ? ~contact_level : contact_level;
    s.heating_active          = 1'($urandom_range(0, 1));
    s.sterilisation_active    = ($urandom_range(0, 11) == 0);
    s.hot_water_in_tank_state = 1'($urandom_range(0, 1));
    s.mode_allows_run         = ($urandom_range(0, 6) != 0);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t next_cfg;
    int   base;
    int   cur_grp;
    step_ch.valid                   <= 1'b0;
    step_ch.second_tick             <= 1'b0;
    step_ch.buffer_temp             <= '0;
    step_ch.thermostat_contact      <= 1'b0;
    step_ch.heating_active          <= 1'b0;
    step_ch.sterilisation_active    <= 1'b0;
    step_ch.hot_water_in_tank_state <= 1'b0;
    step_ch.mode_allows_run         <= 1'b0;
    cfg_we                          <= 1'b0;
    cfg_index                       <= CFG_OFF_TEMP;
    cfg_wdata                       <= '0;
    rst_n                           <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Register groups change only once the block is idle.
    cur_grp = 0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (int'(DIRECTED[i].grp) != cur_grp) begin
        wait_drained();
        cur_grp = int'(DIRECTED[i].grp);
        load_settings(DIRECTED_CFG[cur_grp]);
      end
      offer_step(DIRECTED[i].s, DIRECTED[i].typed_in, DIRECTED[i].want);
      if ($urandom_range(0, 3) == 0) idle_steps($urandom_range(1, 16));
    end

    // Random part: fixed settings for short timers, widest thresholds with
    // longest timers, inverted thresholds with zero timers, then random ones.
    for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
      case (ph)
        0: next_cfg = '{-16'sd50, 16'sd50, 32'd8, 16'd4, 16'd3, 1'b1};
        1: next_cfg = '{16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0};
        2: next_cfg = '{16'sh7FFF, 16'sh8000, 32'd0, 16'd0, 16'd0, 1'b1};
        default: begin
          base = int'($urandom_range(0, 65535)) - 32768;
          next_cfg.off_temperature = base[15:0];
          // mostly a proper band, sometimes inverted
          base = base + int'($urandom_range(0, 60)) - 6;
          if (base > 32767) base = 32767;
          else if (base < -32768) base = -32768;
          next_cfg.on_temperature            = base[15:0];
          next_cfg.max_off_seconds           = $urandom_range(0, 20);
          next_cfg.lag_seconds               = 16'($urandom_range(0, 10));
          next_cfg.forced_on_seconds         = 16'($urandom_range(0, 10));
          next_cfg.emergency_heating_enabled = 1'($urandom_range(0, 1));
        end
      endcase
      wait_drained();
      load_settings(next_cfg);
      quiet = (ph == RANDOM_SETTINGS - 1);

      for (int k = 0; k < STEPS_PER_SETTING; k++) begin
        // long receiver hold-off while steps keep coming: the block fills
        // both stages and must drop its input ready
        if (ph == 1 && k == 20) hold_req = 1'b1;
        // sender pause until every result is back
        if (ph == 2 && k == 75) wait_drained();
        offer_step(random_step(), 1'b0, '0);
        if (!quiet && $urandom_range(0, 7) == 0) idle_steps($urandom_range(1, 16));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d steps and %0d checked results over %0d register settings",
             steps_sent, results_checked, settings_used + 1);
    $display("predicted phases: off %0d, on %0d, lag %0d, forced on %0d; %0d mismatches",
             phase_hits[PHASE_OFF], phase_hits[PHASE_RUN], phase_hits[PHASE_LAG],
             phase_hits[PHASE_FORCED], mismatches);
    if (mismatches == 0 && pending_results.size() == 0 && presets.size() == 0) begin
      $display("** circulation_pump_controller_top: PASSED **");
    end else begin
      $display("** circulation_pump_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
